>>> rtl/sha512_pkg.sv
package sha512_pkg;

  localparam int ROUNDS_DEF = 80;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_beat_t;

  localparam logic [63:0] IV_TAB [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] K_TAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] sig0(input logic [63:0] x);
    sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sig1(input logic [63:0] x);
    sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

>>> rtl/sha512_hash_engine_top.sv
// Flow: a beat is accepted, its bytes are placed in turn, then the end of the beat is checked;
// a beat that fills a 1024-bit block then runs ROUNDS rounds (read, read, round each) and a fold-in.
// Final beat: padding bytes are placed, then one or two compressions, then eight output beats.
// The input is ready only in idle, so a new beat waits until the previous one is fully processed.
// Reset (rst_n low, synchronous): chaining value to IV, counters cleared, window undefined.
module sha512_hash_engine_top #(
  parameter int ROUNDS = sha512_pkg::ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha512_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha512_pkg::out_beat_t out_data
);
  import sha512_pkg::*;

  localparam int RW = $clog2(ROUNDS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BYTE = 3'd1;  // place one byte per cycle
  localparam logic [2:0] S_RD   = 3'd2;  // issue window reads
  localparam logic [2:0] S_RD2  = 3'd3;  // second read pair
  localparam logic [2:0] S_RND  = 3'd4;  // round with read data
  localparam logic [2:0] S_ADD  = 3'd5;  // fold into chaining value
  localparam logic [2:0] S_OUT  = 3'd6;

  // padding phases
  localparam logic [1:0] PAD_DATA = 2'd0;
  localparam logic [1:0] PAD_MARK = 2'd1;
  localparam logic [1:0] PAD_ZERO = 2'd2;
  localparam logic [1:0] PAD_LEN  = 2'd3;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] h_r [8];
  logic [63:0] v_r [8];
  logic [63:0] v_nxt [8];
  logic [63:0] word_r;       // word being assembled
  logic [63:0] data_r;
  logic [3:0]  cnt_r;        // bytes left from input beat
  logic        last_r;
  logic [1:0]  pad_r;        // data, pad 0x80, zeros, length
  logic [63:0] len_r;
  logic [63:0] bits_r;
  logic [3:0]  widx_r;
  logic [2:0]  fill_r;
  logic [4:0]  lcnt_r;       // length field bytes left
  logic [RW-1:0] rnd_r;
  logic [63:0] wa_r, wb_r;   // w[t] and w[t-7] latched
  logic [2:0]  oidx_r;

  logic        we;
  logic [3:0]  waddr, ra, rb;
  logic [63:0] wdata, rda, rdb, wcur;

  sha512_wmem u_wmem (.clk, .we, .waddr, .wdata, .raddr_a(ra), .raddr_b(rb),
                      .rdata_a(rda), .rdata_b(rdb));

  sha512_round u_round (.vin(v_r), .k(K_TAB[rnd_r[6:0]]), .w(wcur), .vout(v_nxt));

  logic [3:0] slot;
  assign slot = rnd_r[3:0];

  // byte to place this cycle
  logic [7:0] byte_v;
  always_comb begin
    case (pad_r)
      PAD_DATA: byte_v = data_r[63:56];
      PAD_MARK: byte_v = 8'h80;
      PAD_LEN:  byte_v = (lcnt_r > 5'd8) ? 8'h00 : len_r[63:56];
      default:  byte_v = 8'h00;
    endcase
  end

  logic [63:0] word_new;
  assign word_new = ((fill_r == 3'd0) ? 64'd0 : word_r) |
                    ({56'd0, byte_v} << (7'd56 - {1'b0, fill_r, 3'b000}));

  // schedule word: read a = w[t], b = w[t-7] in S_RD; a = w[t-15], b = w[t-2] in S_RD2
  always_comb begin
    ra = slot;
    rb = slot - 4'd7;
    if (st_r == S_RD2) begin
      ra = slot - 4'd15;
      rb = slot - 4'd2;
    end
    wcur = (rnd_r < RW'(16)) ? wa_r : (wa_r + wb_r + sig0(rda) + sig1(rdb));
    we = 1'b0;
    waddr = slot;
    wdata = wcur;
    if (st_r == S_BYTE && fill_r == 3'd7) begin
      we = 1'b1;
      waddr = widx_r;
      wdata = word_new;
    end else if (st_r == S_RND && rnd_r >= RW'(16)) begin
      we = 1'b1;
    end
  end

  // control and datapath sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < 8; i++) h_r[i] <= IV_TAB[i];
      widx_r <= '0; fill_r <= '0; bits_r <= '0; rnd_r <= '0;
      pad_r <= PAD_DATA; cnt_r <= '0; last_r <= 1'b0; oidx_r <= '0; lcnt_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) begin
          data_r <= in_data.data_word;
          cnt_r  <= (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
          last_r <= in_data.end_of_message;
          pad_r  <= PAD_DATA;
          st_r   <= S_BYTE;
        end
        S_BYTE: begin
          if (pad_r == PAD_DATA && cnt_r == 4'd0) begin
            if (last_r) begin
              pad_r <= PAD_MARK;
              len_r <= bits_r;
            end else begin
              st_r <= S_IDLE;
            end
          end else if (pad_r == PAD_ZERO && widx_r == 4'd14 && fill_r == 3'd0) begin
            pad_r <= PAD_LEN;
            lcnt_r <= 5'd16;
          end else begin
            word_r <= word_new;
            fill_r <= fill_r + 3'd1;
            case (pad_r)
              PAD_DATA: begin
                data_r <= data_r << 8;
                cnt_r  <= cnt_r - 4'd1;
                bits_r <= bits_r + 64'd8;
              end
              PAD_MARK: pad_r <= PAD_ZERO;
              PAD_LEN: begin
                lcnt_r <= lcnt_r - 5'd1;
                if (lcnt_r <= 5'd8) len_r <= len_r << 8;
              end
              default: ;
            endcase
            if (fill_r == 3'd7) begin
              widx_r <= widx_r + 4'd1;
              if (widx_r == 4'd15) begin
                rnd_r <= '0;
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
                st_r <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          st_r <= S_RD2;
        end
        S_RD2: begin
          wa_r <= rda;
          wb_r <= rdb;
          st_r <= S_RND;
        end
        S_RND: begin
          for (int i = 0; i < 8; i++) v_r[i] <= v_nxt[i];
          if (rnd_r == RW'(ROUNDS - 1)) begin
            st_r <= S_ADD;
          end else begin
            rnd_r <= rnd_r + RW'(1);
            st_r <= S_RD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          rnd_r <= '0;
          // block done in length phase with no length bytes left: output
          if (pad_r == PAD_LEN && lcnt_r == 5'd0) begin
            oidx_r <= '0;
            st_r <= S_OUT;
          end else begin
            st_r <= S_BYTE;
          end
        end
        S_OUT: if (out_ready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) h_r[i] <= IV_TAB[i];
            widx_r <= '0; fill_r <= '0; bits_r <= '0; pad_r <= PAD_DATA;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data.digest_word  = h_r[oidx_r];
  assign out_data.digest_index = oidx_r;
  assign out_data.digest_last  = (oidx_r == 3'd7);

  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input taken during digest output");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RND) |-> (rnd_r < RW'(ROUNDS)))
    else $error("round counter out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.digest_last) |=> in_ready)
    else $error("not idle after last digest word");
endmodule

>>> rtl/sha512_wmem.sv
// Schedule window: 16 x 64 synchronous memory, one write and two read ports
module sha512_wmem (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [3:0]  raddr_a,
  input  logic [3:0]  raddr_b,
  output logic [63:0] rdata_a,
  output logic [63:0] rdata_b
);
  logic [63:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> rtl/sha512_round.sv
// One SHA-512 round over the working variables
module sha512_round (
  input  logic [63:0] vin [8],
  input  logic [63:0] k,
  input  logic [63:0] w,
  output logic [63:0] vout [8]
);
  import sha512_pkg::*;
  logic [63:0] t1, t2, ch, mj;

  always_comb begin
    ch = (vin[4] & vin[5]) ^ (~vin[4] & vin[6]);
    mj = (vin[0] & vin[1]) ^ (vin[0] & vin[2]) ^ (vin[1] & vin[2]);
    t1 = vin[7] + (rotr(vin[4], 14) ^ rotr(vin[4], 18) ^ rotr(vin[4], 41)) + ch + k + w;
    t2 = (rotr(vin[0], 28) ^ rotr(vin[0], 34) ^ rotr(vin[0], 39)) + mj;
    vout[0] = t1 + t2;
    vout[1] = vin[0];
    vout[2] = vin[1];
    vout[3] = vin[2];
    vout[4] = vin[3] + t1;
    vout[5] = vin[4];
    vout[6] = vin[5];
    vout[7] = vin[6];
  end
endmodule

>>> test/tb_top.sv
module tb_top;
  import sha512_pkg::*;

  localparam int MSG_ITEMS  = 220;
  localparam int QUIET_TAIL = 40;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYC  = 50;
  localparam int N_ROWS     = 11;

  // initial chaining value and round constants
  localparam logic [63:0] H_INIT [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam logic [63:0] RC [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // well-known digests of the empty string and of "abc"
  localparam logic [63:0] EMPTY_HASH [8] = '{
    64'hcf83e1357eefb8bd, 64'hf1542850d66d8007, 64'hd620e4050b5715dc, 64'h83f4a921d36ce9ce,
    64'h47d0d13c5d85f2b0, 64'hff8318d2877eec2f, 64'h63b931bd47417a81, 64'ha538327af927da3e
  };
  localparam logic [63:0] ABC_HASH [8] = '{
    64'hddaf35a193617aba, 64'hcc417349ae204131, 64'h12e6fa4e89a97ea2, 64'h0a9eeee64b55d39a,
    64'h2192992a274fc1a8, 64'h36ba3c23a3feebbd, 64'h454d4423643ce80e, 64'h2a9ac94fa54ca49f
  };

  // directed beats: data, byte count, end of message
  localparam in_beat_t DIR_ROWS [N_ROWS] = '{
    '{64'h0000000000000000, 4'd0,  1'b1},  // empty message
    '{64'h6162630000000000, 4'd3,  1'b1},  // "abc"
    '{64'hffffffffffffffff, 4'd8,  1'b1},
    '{64'h0000000000000000, 4'd8,  1'b1},
    '{64'h0123456789abcdef, 4'd15, 1'b0},  // oversize count acts as eight
    '{64'hfedcba9876543210, 4'd0,  1'b0},  // adds nothing
    '{64'h1122334455667788, 4'd5,  1'b0},  // short word mid-message
    '{64'h99aabbccddeeff00, 4'd9,  1'b0},
    '{64'hffffffffffffffff, 4'd1,  1'b1},
    '{64'h8000000000000001, 4'd12, 1'b0},
    '{64'hdeadbeefcafef00d, 4'd7,  1'b1}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // hashing state of the predictor
  logic [63:0] hv [8];
  logic [63:0] wsched [16];
  int          wpos;
  int          bpos;
  logic [63:0] bit_len;

  out_beat_t digest_q [$];
  bit        quiet = 1'b0;
  int        n_beats = 0;
  int        n_msgs = 0;
  int        n_digests = 0;
  int        n_bad = 0;
  int        idle_cyc = 0;
  int        stall_left = 0;

  always #1 clk = ~clk;

  sha512_hash_engine_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    logic [127:0] d;
    d = {x, x} >> n;
    return d[63:0];
  endfunction

  task automatic hash_clear();
    for (int i = 0; i < 8; i++) hv[i] = H_INIT[i];
    for (int i = 0; i < 16; i++) wsched[i] = '0;
    wpos = 0;
    bpos = 0;
    bit_len = '0;
  endtask

  // one 80-round compression of the 16-word window
  task automatic compress_blk();
    logic [63:0] v [8];
    logic [63:0] w, w15, w2, t1, t2, e, a;
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = wsched[r];
      end else begin
        w15 = wsched[(r - 15) & 15];
        w2  = wsched[(r - 2) & 15];
        w = wsched[r & 15] + (ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7))
            + wsched[(r - 7) & 15] + (ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6));
        wsched[r & 15] = w;
      end
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
           + ((e & v[5]) ^ (~e & v[6])) + RC[r] + w;
      t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
           + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endtask

  task automatic pack_byte(logic [7:0] b);
    if (bpos == 0) wsched[wpos] = '0;
    wsched[wpos][63 - 8*bpos -: 8] = b;
    bpos++;
    if (bpos == 8) begin
      bpos = 0;
      wpos++;
      if (wpos == 16) begin
        wpos = 0;
        compress_blk();
      end
    end
  endtask

  // absorb one beat; on end of message, pad and return the eight digest words
  task automatic absorb_beat(in_beat_t b, ref out_beat_t res [$]);
    int cnt;
    logic [63:0] len;
    out_beat_t o;
    cnt = (b.byte_count > 8) ? 8 : b.byte_count;
    for (int i = 0; i < cnt; i++) begin
      pack_byte(b.data_word[63 - 8*i -: 8]);
      bit_len += 64'd8;
    end
    if (b.end_of_message) begin
      len = bit_len;
      pack_byte(8'h80);
      while (!(wpos == 14 && bpos == 0)) pack_byte(8'h00);
      for (int i = 0; i < 8; i++) pack_byte(8'h00);
      for (int i = 0; i < 8; i++) pack_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word  = hv[i];
        o.digest_index = i[2:0];
        o.digest_last  = (i == 7);
        res.push_back(o);
      end
      hash_clear();
    end
  endtask

  // present one beat and wait for it to be taken; with use_typed set, typed_hash overrides the predictor
  task automatic send_beat(in_beat_t b, bit use_typed, logic [63:0] typed_hash [8]);
    out_beat_t res [$];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_beats++;
    absorb_beat(b, res);
    if (res.size() != 0) n_msgs++;
    for (int i = 0; i < res.size(); i++) begin
      if (use_typed) res[i].digest_word = typed_hash[i];
      digest_q.push_back(res[i]);
    end
  endtask

  function automatic in_beat_t rand_beat(bit eom);
    in_beat_t b;
    b.data_word = {$urandom, $urandom};
    if (eom || $urandom_range(0, 9) < 2) b.byte_count = 4'($urandom_range(0, 15));
    else b.byte_count = 4'd8;
    b.end_of_message = eom;
    return b;
  endfunction

  // result side: random stall bursts, none in the tail
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // digest checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_digests++;
      if (digest_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected digest beat %h", out_data);
      end else begin
        if (out_data.digest_word !== digest_q[0].digest_word
            || out_data.digest_index !== digest_q[0].digest_index
            || out_data.digest_last !== digest_q[0].digest_last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                     digest_q[0].digest_word, digest_q[0].digest_index,
                     digest_q[0].digest_last, out_data.digest_word,
                     out_data.digest_index, out_data.digest_last);
        end
        void'(digest_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cyc);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] hsel [8];
    int nw;
    hash_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int k = 0; k < N_ROWS; k++) begin
      if (k == 0) hsel = EMPTY_HASH;
      else hsel = ABC_HASH;
      send_beat(DIR_ROWS[k], k < 2, hsel);
    end

    // random messages, mostly full words, lengths crossing block edges
    while (n_beats < MSG_ITEMS) begin
      nw = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 34) : $urandom_range(0, 15);
      for (int i = 0; i < nw; i++) begin
        if (n_beats >= MSG_ITEMS - 1) break;
        if (n_beats >= MSG_ITEMS - QUIET_TAIL) quiet = 1'b1;
        send_beat(rand_beat(1'b0), 1'b0, hsel);
      end
      send_beat(rand_beat(1'b1), 1'b0, hsel);
    end
    in_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d input beats in %0d messages, %0d digest beats checked",
             n_beats, n_msgs, n_digests);
    if (n_bad == 0 && digest_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d digest beats wrong", n_bad);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
